// ----- rtl/core/tws_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tws_pkg;

  // Default depth of the outgoing byte queue
  localparam int OUT_DEPTH_DEF = 16;

  // Request commands
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  // Configuration register indexes
  localparam logic REG_HALF_PERIOD = 1'b0;
  localparam logic REG_LSB_FIRST   = 1'b1;

  // Transfer phases
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_TX_LOW  = 3'd1;
  localparam logic [2:0] PH_TX_HIGH = 3'd2;
  localparam logic [2:0] PH_GAP     = 3'd3;
  localparam logic [2:0] PH_RX_LOW  = 3'd4;
  localparam logic [2:0] PH_RX_HIGH = 3'd5;

  // One result per request
  typedef struct packed {
    logic       cs_n;
    logic       sclk;
    logic       dio_out;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       busy_res;
    logic       done_res;
    logic       rejected;
  } tws_res_t;

  // Bit that goes out on the data pin for a given shift register
  function automatic logic tx_bit(input logic [7:0] sr, input logic lsb);
    tx_bit = lsb ? sr[0] : sr[7];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tws_buf.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Outgoing byte queue: one write port, one read port with registered data
module tws_buf import tws_pkg::*; #(
  parameter int OUT_DEPTH = OUT_DEPTH_DEF,
  parameter int AW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic [7:0]         rd_data
);

  logic [7:0] mem [OUT_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/tws_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Transfer state machine: applies one request per accepted cycle
module tws_engine import tws_pkg::*; #(
  parameter int OUT_DEPTH = OUT_DEPTH_DEF,
  parameter int AW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1,
  parameter int FW = $clog2(OUT_DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [15:0]   cfg_data,
  input  wire logic          fire,
  input  wire logic [1:0]    command,
  input  wire logic [7:0]    byte_value,
  input  wire logic [4:0]    out_count,
  input  wire logic [7:0]    in_count,
  input  wire logic [7:0]    gap_delay,
  input  wire logic          release_cs,
  input  wire logic          dio_in,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [7:0]         wr_data,
  output logic [AW-1:0]      rd_addr,
  input  wire logic [7:0]    rd_data,
  output tws_res_t           res
);

  localparam int CW = (FW > 5) ? FW : 5;

  // Configuration
  logic [15:0] half_period;
  logic        lsb_first;

  // Transfer state
  logic [2:0]    phase,        phase_next;
  logic [15:0]   tick_counter, tick_counter_next;
  logic [2:0]    bit_index,    bit_index_next;
  logic [7:0]    shift_reg,    shift_reg_next;
  logic [FW-1:0] buffer_fill,  buffer_fill_next;
  logic [FW-1:0] out_left,     out_left_next;
  logic [7:0]    in_left,      in_left_next;
  logic [7:0]    gap_left,     gap_left_next;
  logic          end_release,  end_release_next;
  logic          pin_cs,       pin_cs_next;
  logic          pin_clk,      pin_clk_next;
  logic          pin_dio,      pin_dio_next;

  logic          busy;
  logic          rej, done, rxv;
  logic [7:0]    rxb;
  logic [16:0]   hp_ext, cnt_ext;
  logic          half_done;
  logic [15:0]   tick_after;
  logic [7:0]    rx_shift;
  logic [FW-1:0] fetch_idx;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= 16'd1;
      lsb_first   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HALF_PERIOD: half_period <= cfg_data;
        REG_LSB_FIRST:   lsb_first   <= cfg_data[0];
        default:         ;
      endcase
    end
  end

  // Half-period counter step; zero period acts as one
  always_comb begin
    hp_ext     = (half_period == 16'd0) ? 17'd1 : {1'b0, half_period};
    cnt_ext    = {1'b0, tick_counter} + 17'd1;
    half_done  = cnt_ext >= hp_ext;
    tick_after = half_done ? 16'd0 : cnt_ext[15:0];
    rx_shift   = lsb_first ? {dio_in, shift_reg[7:1]} : {shift_reg[6:0], dio_in};
    fetch_idx  = buffer_fill - out_left;
  end

  // Next-state logic
  always_comb begin
    phase_next        = phase;
    tick_counter_next = tick_counter;
    bit_index_next    = bit_index;
    shift_reg_next    = shift_reg;
    buffer_fill_next  = buffer_fill;
    out_left_next     = out_left;
    in_left_next      = in_left;
    gap_left_next     = gap_left;
    end_release_next  = end_release;
    pin_cs_next       = pin_cs;
    pin_clk_next      = pin_clk;
    pin_dio_next      = pin_dio;
    busy              = phase != PH_IDLE;
    rej               = 1'b0;
    done              = 1'b0;
    rxv               = 1'b0;
    rxb               = 8'd0;
    wr_en             = 1'b0;
    wr_addr           = buffer_fill[AW-1:0];
    wr_data           = byte_value;

    case (command)
      CMD_LOAD: begin
        if (busy || buffer_fill >= FW'(OUT_DEPTH)) begin
          rej = 1'b1;
        end else begin
          wr_en            = fire;
          buffer_fill_next = buffer_fill + FW'(1);
        end
      end
      CMD_START: begin
        if (busy || CW'(out_count) > CW'(buffer_fill)) begin
          rej = 1'b1;
        end else begin
          buffer_fill_next  = FW'(out_count);
          out_left_next     = FW'(out_count);
          in_left_next      = in_count;
          gap_left_next     = gap_delay;
          end_release_next  = release_cs;
          shift_reg_next    = byte_value;
          bit_index_next    = 3'd0;
          tick_counter_next = 16'd0;
          pin_cs_next       = 1'b0;
          pin_clk_next      = 1'b0;
          pin_dio_next      = tx_bit(byte_value, lsb_first);
          phase_next        = PH_TX_LOW;
        end
      end
      default: begin
        // Tick: advance bit timing
        if (busy && phase <= PH_RX_HIGH) begin
          tick_counter_next = tick_after;
        end
        case (phase)
          PH_TX_LOW: begin
            if (half_done) begin
              pin_clk_next = 1'b1;
              if (bit_index == 3'd7 && out_left == '0 && in_left == 8'd0) begin
                done = 1'b1;
              end else begin
                phase_next = PH_TX_HIGH;
              end
            end
          end
          PH_TX_HIGH: begin
            if (half_done) begin
              pin_clk_next   = 1'b0;
              bit_index_next = bit_index + 3'd1;
              if (bit_index != 3'd7) begin
                shift_reg_next = lsb_first ? {1'b0, shift_reg[7:1]} : {shift_reg[6:0], 1'b0};
                pin_dio_next   = tx_bit(shift_reg_next, lsb_first);
                phase_next     = PH_TX_LOW;
              end else if (out_left != '0) begin
                // Next queued byte, prefetched from the buffer
                shift_reg_next = rd_data;
                out_left_next  = out_left - FW'(1);
                pin_dio_next   = tx_bit(rd_data, lsb_first);
                phase_next     = PH_TX_LOW;
              end else if (gap_left != 8'd0) begin
                phase_next = PH_GAP;
              end else begin
                in_left_next   = in_left - 8'd1;
                shift_reg_next = 8'd0;
                bit_index_next = 3'd0;
                pin_dio_next   = 1'b1;
                phase_next     = PH_RX_LOW;
              end
            end
          end
          PH_GAP: begin
            if (half_done) begin
              gap_left_next = gap_left - 8'd1;
              if (gap_left == 8'd1) begin
                in_left_next   = in_left - 8'd1;
                shift_reg_next = 8'd0;
                bit_index_next = 3'd0;
                pin_dio_next   = 1'b1;
                phase_next     = PH_RX_LOW;
              end
            end
          end
          PH_RX_LOW: begin
            if (half_done) begin
              shift_reg_next = rx_shift;
              pin_clk_next   = 1'b1;
              if (bit_index == 3'd7) begin
                rxv = 1'b1;
                rxb = rx_shift;
              end
              if (bit_index == 3'd7 && in_left == 8'd0) begin
                done = 1'b1;
              end else begin
                phase_next = PH_RX_HIGH;
              end
            end
          end
          PH_RX_HIGH: begin
            if (half_done) begin
              pin_clk_next   = 1'b0;
              bit_index_next = bit_index + 3'd1;
              if (bit_index == 3'd7) begin
                in_left_next   = in_left - 8'd1;
                shift_reg_next = 8'd0;
                bit_index_next = 3'd0;
                pin_dio_next   = 1'b1;
                phase_next     = PH_RX_LOW;
              end else begin
                phase_next = PH_RX_LOW;
              end
            end
          end
          PH_IDLE: ;
          default: phase_next = PH_IDLE;
        endcase
        // Transaction end
        if (done) begin
          phase_next       = PH_IDLE;
          buffer_fill_next = '0;
          out_left_next    = '0;
          if (end_release) begin
            pin_cs_next = 1'b1;
          end
        end
      end
    endcase
  end

  // Read ahead through the registered port at the index the next state will fetch from
  always_comb begin
    if (fire) begin
      rd_addr = FW'(buffer_fill_next - out_left_next) >> 0 == '0 ? '0 :
                AW'(buffer_fill_next - out_left_next);
    end else begin
      rd_addr = fetch_idx[AW-1:0];
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tick_counter <= 16'd0;
      bit_index    <= 3'd0;
      shift_reg    <= 8'd0;
      buffer_fill  <= '0;
      out_left     <= '0;
      in_left      <= 8'd0;
      gap_left     <= 8'd0;
      end_release  <= 1'b0;
      pin_cs       <= 1'b1;
      pin_clk      <= 1'b0;
      pin_dio      <= 1'b0;
    end else if (fire) begin
      phase        <= phase_next;
      tick_counter <= tick_counter_next;
      bit_index    <= bit_index_next;
      shift_reg    <= shift_reg_next;
      buffer_fill  <= buffer_fill_next;
      out_left     <= out_left_next;
      in_left      <= in_left_next;
      gap_left     <= gap_left_next;
      end_release  <= end_release_next;
      pin_cs       <= pin_cs_next;
      pin_clk      <= pin_clk_next;
      pin_dio      <= pin_dio_next;
    end
  end

  // Result of this request
  always_comb begin
    res.cs_n     = pin_cs_next;
    res.sclk     = pin_clk_next;
    res.dio_out  = pin_dio_next;
    res.rx_byte  = rxb;
    res.rx_valid = rxv;
    res.busy_res = phase_next != PH_IDLE;
    res.done_res = done;
    res.rejected = rej;
  end

endmodule

`default_nettype wire

// ----- rtl/core/tws_outq.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Output register with skid stage
module tws_outq import tws_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire tws_res_t  push_data,
  output logic           can_push,
  output logic           out_valid,
  input  wire logic      out_ready,
  output tws_res_t       head_data
);

  logic     main_valid;
  logic     skid_valid;
  tws_res_t main_data;
  tws_res_t skid_data;
  logic     pop;

  assign pop       = main_valid && out_ready;
  assign can_push  = !skid_valid;
  assign out_valid = main_valid;
  assign head_data = main_data;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_data <= skid_data;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        main_data <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/three_wire_spi_master.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Payload
// input     in_valid / in_ready    command, byte_value, out_count, in_count,
//                                  gap_delay, release_cs, dio_in
// output    out_valid / out_ready  cs_n, sclk, dio_out, rx_byte, rx_valid,
//                                  busy_res, done_res, rejected
// config    cfg_we                 cfg_index, cfg_data
//
// One request per clock while in_ready is high; its result is registered in the output stage.
// The byte queue is read ahead through its registered port at the index the next state fetches.
// Output register plus skid stage: input stalls only when both are full.
// rst is synchronous; the byte queue has no clear and entries are read only
// after being loaded.
module three_wire_spi_master import tws_pkg::*; #(
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  command,
  input  wire logic [7:0]  byte_value,
  input  wire logic [4:0]  out_count,
  input  wire logic [7:0]  in_count,
  input  wire logic [7:0]  gap_delay,
  input  wire logic        release_cs,
  input  wire logic        dio_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             cs_n,
  output logic             sclk,
  output logic             dio_out,
  output logic [7:0]       rx_byte,
  output logic             rx_valid,
  output logic             busy_res,
  output logic             done_res,
  output logic             rejected
);

  localparam int AW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;

  logic          fire;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  tws_res_t      res;
  tws_res_t      res_q;

  assign fire = in_valid && in_ready;

  tws_buf #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tws_engine #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fire       (fire),
    .command    (command),
    .byte_value (byte_value),
    .out_count  (out_count),
    .in_count   (in_count),
    .gap_delay  (gap_delay),
    .release_cs (release_cs),
    .dio_in     (dio_in),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .res        (res)
  );

  tws_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_data (res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head_data (res_q)
  );

  assign cs_n     = res_q.cs_n;
  assign sclk     = res_q.sclk;
  assign dio_out  = res_q.dio_out;
  assign rx_byte  = res_q.rx_byte;
  assign rx_valid = res_q.rx_valid;
  assign busy_res = res_q.busy_res;
  assign done_res = res_q.done_res;
  assign rejected = res_q.rejected;

endmodule

`default_nettype wire
